FILE: src/sks_pkg.sv
package sks_pkg;

	localparam int unsigned MeasW  = 16;
	localparam int unsigned ErrW   = 24;
	localparam int unsigned NoiseW = 16;
	localparam int unsigned GainW  = 17;
	localparam int unsigned DenW   = 25;
	localparam int unsigned MulAW  = 24;
	localparam int unsigned MulBW  = 17;
	localparam int unsigned ProdW  = MulAW + MulBW;

	localparam logic [1:0] REG_MEAS_ERR  = 2'd0;
	localparam logic [1:0] REG_INIT_ERR  = 2'd1;
	localparam logic [1:0] REG_PROC_NOISE = 2'd2;

	localparam logic [ErrW-1:0]   RESET_MEAS_ERR   = 24'd131072;
	localparam logic [ErrW-1:0]   RESET_INIT_ERR   = 24'd131072;
	localparam logic [NoiseW-1:0] RESET_PROC_NOISE = 16'd9830;

	localparam logic [GainW-1:0] GAIN_ONE = 17'h10000;
	localparam logic [ErrW-1:0]  ERR_MAX  = 24'hFFFFFF;

	typedef struct packed {
		logic            start;
		logic [ErrW-1:0] num;
		logic [DenW-1:0] den;
	} sks_div_req_t;

	typedef struct packed {
		logic             done;
		logic [GainW-1:0] quot;
	} sks_div_rsp_t;

endpackage

FILE: src/sks_div.sv
// Restoring divider: quot = floor(num * 2^16 / den), one quotient bit per cycle.
// Requires num < 2*den, so 17 quotient bits suffice.
module sks_div
	import sks_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  sks_div_req_t req,
	output sks_div_rsp_t rsp
);

	logic [DenW-1:0]  rem_q;
	logic [DenW-1:0]  den_q;
	logic [GainW-1:0] quot_q;
	logic [4:0]       cnt_q;
	logic             busy_q;
	logic             lsb_q;
	logic             done_q;

	logic [DenW:0] shifted;
	logic [DenW:0] diff;
	logic          fits;

	// only the top quotient step pulls in a dividend bit (num[0]); the rest are zero
	assign shifted = {rem_q, (cnt_q == 5'd16) ? lsb_q : 1'b0};
	assign diff    = shifted - {1'b0, den_q};
	assign fits    = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd16;
			end else if (busy_q) begin
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 5'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= {2'b00, req.num[ErrW-1:1]};
			lsb_q  <= req.num[0];
			den_q  <= req.den;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? diff[DenW-1:0] : shifted[DenW-1:0];
			quot_q <= {quot_q[GainW-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

FILE: src/sks_mul.sv
// Shared multiplier, product registered.
module sks_mul
	import sks_pkg::*;
(
	input  logic             clk,
	input  logic [MulAW-1:0] a,
	input  logic [MulBW-1:0] b,
	output logic [ProdW-1:0] p
);

	logic [ProdW-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= ProdW'(a) * ProdW'(b);
	end

	assign p = p_q;

endmodule

FILE: src/scalar_kalman_smoother.sv
// Channel  | Signals                               | Payload
// ---------+---------------------------------------+-------------------------------
// s_axis   | s_tvalid s_tready s_tdata[15:0]       | measurement, Q8.8 unsigned
// m_axis   | m_tvalid m_tready m_tdata[15:0]       | estimate, Q8.8 unsigned
// cfg      | cfg_valid cfg_ready cfg_index cfg_data| register index, write data
//
// Each measurement passes from its transfer through the bit-serial gain
// divider, the gain capture, the passes through the shared 24x17 multiplier
// and the final error update before its estimate is shown. The next
// measurement is not taken until the current one is finished.
// s_tready is high only while the sequencer is idle. A stalled m_axis holds the
// last step until the prior estimate is taken. Async reset loads the register
// defaults, clears the estimate and sets the error to the initial error.
module scalar_kalman_smoother
	import sks_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [MeasW-1:0]  s_tdata,   // [15:0] measurement
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [MeasW-1:0]  m_tdata,   // [15:0] estimate
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [ErrW-1:0]   cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_MAG,
		ST_T1,
		ST_T2,
		ST_DONE
	} state_t;

	state_t state_q;

	// configuration
	logic [ErrW-1:0]   meas_err_q;
	logic [NoiseW-1:0] noise_q;

	// filter state
	logic [MeasW-1:0] last_q;
	logic [ErrW-1:0]  err_q;

	// per-item work registers
	logic [MeasW-1:0] meas_q;
	logic [GainW-1:0] gain_q;
	logic [MeasW-1:0] next_q;
	logic [DenW:0]    term1_q;
	logic [MeasW-1:0] out_data_q;
	logic             out_valid_q;

	logic             s_xfer;
	logic             cfg_xfer;
	logic             up;
	logic [MeasW-1:0] mag;
	logic [MeasW-1:0] moved;
	logic [MeasW-1:0] corr;
	logic [MeasW-1:0] next_val;
	logic [ProdW:0]   rnd16;
	logic [ProdW:0]   rnd8;
	logic [DenW:0]    term2;
	logic [DenW+1:0]  err_sum;
	logic [ErrW-1:0]  err_new;
	logic             den_zero;

	logic [MulAW-1:0] mul_a;
	logic [MulBW-1:0] mul_b;
	logic [ProdW-1:0] prod;

	sks_div_req_t div_req;
	sks_div_rsp_t div_rsp;

	assign s_tready  = (state_q == ST_IDLE);
	assign s_xfer    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign cfg_xfer  = cfg_valid && cfg_ready;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;

	// gain = E / (E + R) as Q1.16; started on the input transfer
	assign div_req.start = s_xfer;
	assign div_req.num   = err_q;
	assign div_req.den   = {1'b0, err_q} + {1'b0, meas_err_q};
	assign den_zero      = (err_q == '0) && (meas_err_q == '0);

	sks_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// direction and size of the innovation
	assign up    = meas_q >= last_q;
	assign mag   = up ? (meas_q - last_q) : (last_q - meas_q);
	assign moved = up ? (next_q - last_q) : (last_q - next_q);

	// operand select for the shared multiplier; the product is registered and lands in the next cycle.
	// term two operands stay up in ST_DONE so the product holds through a stall.
	always_comb begin
		case (state_q)
			ST_MAG: begin
				mul_a = {8'b0, mag};
				mul_b = gain_q;
			end
			ST_T1: begin
				mul_a = err_q;
				mul_b = GAIN_ONE - gain_q;
			end
			ST_T2, ST_DONE: begin
				mul_a = {8'b0, moved};
				mul_b = {1'b0, noise_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	sks_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	// round half up: Q8.24 -> Q8.8 for the correction, 32 -> 16 fraction bits for term one
	assign rnd16    = {1'b0, prod} + (ProdW+1)'(32768);
	assign corr     = rnd16[31:16];
	assign next_val = up ? (last_q + corr) : (last_q - corr);

	// term two: Q8.24 -> Q8.16
	assign rnd8    = {1'b0, prod} + (ProdW+1)'(128);
	assign term2   = rnd8[DenW+8:8];
	assign err_sum = {1'b0, term1_q} + {1'b0, term2};
	assign err_new = (err_sum > (DenW+2)'(ERR_MAX)) ? ERR_MAX : err_sum[ErrW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			meas_err_q  <= RESET_MEAS_ERR;
			noise_q     <= RESET_PROC_NOISE;
			last_q      <= '0;
			err_q       <= RESET_INIT_ERR;
			out_valid_q <= 1'b0;
		end else begin
			// in ST_DONE the output register is reloaded below instead
			if (out_valid_q && m_tready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_xfer) begin
				case (cfg_index)
					REG_MEAS_ERR:   meas_err_q <= cfg_data;
					REG_INIT_ERR: begin
						err_q      <= cfg_data;
						last_q     <= '0;
					end
					REG_PROC_NOISE: noise_q <= cfg_data[NoiseW-1:0];
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (s_xfer) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_MAG;
					end
				end
				ST_MAG: state_q <= ST_T1;
				ST_T1:  state_q <= ST_T2;
				ST_T2:  state_q <= ST_DONE;
				ST_DONE: begin
					if (!out_valid_q || m_tready) begin
						last_q      <= next_q;
						err_q       <= err_new;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_xfer) begin
			meas_q <= s_tdata;
		end
		if (state_q == ST_DIV && div_rsp.done) begin
			gain_q <= den_zero ? '0 : div_rsp.quot;
		end
		if (state_q == ST_T1) begin
			next_q <= next_val;
		end
		if (state_q == ST_T2) begin
			term1_q <= rnd16[DenW+16:16];
		end
		if (state_q == ST_DONE && (!out_valid_q || m_tready)) begin
			out_data_q <= next_q;
		end
	end

endmodule
